[rtl/uadc_pkg.sv]
// uadc_pkg: constants, pattern tables and helper functions of the user-agent classifier
// used by uadc_match and user_agent_device_classifier_core; no dependencies
package uadc_pkg;

  localparam int POS_LIMIT_I = 63;
  localparam int POS_W       = $clog2(POS_LIMIT_I + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

  localparam int PAT_N      = 19;
  localparam int MOZ_END    = 16;
  localparam int MAX_CHARS  = 44;
  localparam int PAT_TEXT_W = 8 * MAX_CHARS;
  localparam int LEN_W      = 6;

  // text literals are right-justified: char i of a length-n text sits at byte n-1-i
  localparam logic [PAT_TEXT_W-1:0] BRAND_TEXT [2] = '{"Mozilla/", "Opera/"};
  localparam logic [LEN_W-1:0]      BRAND_LEN  [2] = '{6'd8, 6'd6};

  localparam logic [PAT_TEXT_W-1:0] PAT_TEXT [PAT_N] = '{
    "(iPhone;",
    "(iPod;",
    "(iPad;",
    "(Linux; U; Android",
    "(Android",
    "(BlackBerry;",
    "(X11;",
    "(Macintosh;",
    "(Windows; U; MSIE",
    "(Windows NT",
    "(Windows; U; Windows NT",
    "(compatible; Windows; U;",
    "(compatible; MSIE 10.0; Macintosh;",
    "(compatible; MSIE 9.0; Windows Phone",
    "(compatible; MSIE 10.0; Windows NT 6.2; ARM;",
    "(compatible; MSIE",
    "(Windows",
    "(Macintosh;",
    "(X11;"
  };

  localparam logic [LEN_W-1:0] PAT_LEN [PAT_N] = '{
    6'd8, 6'd6, 6'd6, 6'd18, 6'd8, 6'd12, 6'd5, 6'd11, 6'd17, 6'd11,
    6'd23, 6'd24, 6'd34, 6'd36, 6'd44, 6'd17, 6'd8, 6'd11, 6'd5
  };

  localparam logic [LEN_W-1:0] PAT_OFF [PAT_N] = '{
    6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12,
    6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd11, 6'd11, 6'd11
  };

  typedef enum logic [2:0] {
    OS_NONE       = 3'd0,
    OS_IOS        = 3'd1,
    OS_ANDROID    = 3'd2,
    OS_BLACKBERRY = 3'd3,
    OS_LINUX      = 3'd4,
    OS_MAC        = 3'd5,
    OS_WINDOWS    = 3'd6,
    OS_WINPHONE   = 3'd7
  } os_kind_t;

  typedef enum logic [2:0] {
    DEV_NONE       = 3'd0,
    DEV_HANDSET    = 3'd1,
    DEV_PLAYER     = 3'd2,
    DEV_TABLET     = 3'd3,
    DEV_MOBILE     = 3'd4,
    DEV_BLACKBERRY = 3'd5,
    DEV_PC         = 3'd6,
    DEV_MAC        = 3'd7
  } device_kind_t;

  localparam os_kind_t PAT_OS [PAT_N] = '{
    OS_IOS, OS_IOS, OS_IOS, OS_ANDROID, OS_ANDROID, OS_BLACKBERRY, OS_LINUX,
    OS_MAC, OS_WINDOWS, OS_WINDOWS, OS_WINDOWS, OS_WINDOWS, OS_MAC,
    OS_WINPHONE, OS_WINPHONE, OS_WINDOWS, OS_WINDOWS, OS_MAC, OS_LINUX
  };

  localparam device_kind_t PAT_DEV [PAT_N] = '{
    DEV_HANDSET, DEV_PLAYER, DEV_TABLET, DEV_MOBILE, DEV_MOBILE, DEV_BLACKBERRY,
    DEV_PC, DEV_MAC, DEV_PC, DEV_PC, DEV_PC, DEV_PC, DEV_MAC, DEV_MOBILE,
    DEV_MOBILE, DEV_PC, DEV_PC, DEV_MAC, DEV_PC
  };

  typedef struct packed {
    os_kind_t     os_kind;
    device_kind_t device_kind;
  } uadc_result_t;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // true when pos falls inside the pattern window and the folded byte differs
  function automatic logic pat_miss(logic [PAT_TEXT_W-1:0] text, logic [LEN_W-1:0] plen,
                                    logic [LEN_W-1:0] poff, logic [POS_W-1:0] pos,
                                    logic [7:0] folded);
    logic [8:0]            p;
    logic [8:0]            lo;
    logic [8:0]            hi;
    logic [LEN_W-1:0]      idx;
    logic [PAT_TEXT_W-1:0] sh;
    logic [7:0]            ch;
    p   = 9'(pos);
    lo  = 9'(poff);
    hi  = 9'(poff) + 9'(plen);
    idx = LEN_W'(9'(plen) - 9'd1 - (p - lo));
    sh  = text >> {idx, 3'b000};
    ch  = fold_case(sh[7:0]);
    return (p >= lo) && (p < hi) && (ch != folded);
  endfunction

endpackage

[rtl/uadc_match.sv]
// uadc_match: per-string match state (position, brand and pattern alive flags)
// and first-match result selection; depends on uadc_pkg
module uadc_match import uadc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_en,
  input  logic [7:0]   ua_byte,
  input  logic         is_last,
  output uadc_result_t result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       brand_alive_r, brand_alive_nxt;
  logic [PAT_N-1:0] pat_alive_r, pat_alive_nxt;
  logic [7:0]       folded;
  logic [8:0]       len;
  logic             moz_ok, opera_ok;

  assign folded  = fold_case(ua_byte);
  assign pos_nxt = (pos_r < POS_LIMIT) ? pos_r + POS_W'(1) : pos_r;
  assign len     = 9'(pos_nxt);

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      brand_alive_nxt[b] = brand_alive_r[b] &
                           ~pat_miss(BRAND_TEXT[b], BRAND_LEN[b], '0, pos_r, folded);
    end
    for (int k = 0; k < PAT_N; k++) begin
      pat_alive_nxt[k] = pat_alive_r[k] &
                         ~pat_miss(PAT_TEXT[k], PAT_LEN[k], PAT_OFF[k], pos_r, folded);
    end
  end

  assign moz_ok   = brand_alive_nxt[0] && (len > 9'(BRAND_LEN[0]));
  assign opera_ok = !moz_ok && brand_alive_nxt[1] && (len > 9'(BRAND_LEN[1]));

  // scan from the back so the lowest eligible pattern wins
  always_comb begin
    result.os_kind     = OS_NONE;
    result.device_kind = DEV_NONE;
    for (int i = PAT_N - 1; i >= 0; i--) begin
      if (((i < MOZ_END) ? moz_ok : opera_ok) && pat_alive_nxt[i] &&
          (len > 9'(PAT_OFF[i]) + 9'(PAT_LEN[i]))) begin
        result.os_kind     = PAT_OS[i];
        result.device_kind = PAT_DEV[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      brand_alive_r <= '1;
      pat_alive_r   <= '1;
    end else if (byte_en) begin
      if (is_last) begin
        pos_r         <= '0;
        brand_alive_r <= '1;
        pat_alive_r   <= '1;
      end else begin
        pos_r         <= pos_nxt;
        brand_alive_r <= brand_alive_nxt;
        pat_alive_r   <= pat_alive_nxt;
      end
    end
  end

endmodule

[rtl/user_agent_device_classifier_core.sv]
// user_agent_device_classifier_core: top level with byte input channel and
// result register; depends on uadc_pkg and uadc_match
//
// Classifies an HTTP user-agent string streamed one byte per transaction, with
// in_is_last on the final byte. Strings stream back to back at one byte per clock
// except while in_ready is low; the per-pattern compare and the
// first-match selection finish in the cycle the byte is accepted. One result
// transaction (os kind, device kind) follows each final byte, valid in the next
// cycle from a single output register. in_ready drops only while that register
// holds a result that out_ready has not taken. No other bytes produce output.
module user_agent_device_classifier_core import uadc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ua_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_os_kind,
  output logic [2:0] out_device_kind
);

  logic         in_fire;
  logic         out_valid_r;
  uadc_result_t res;
  uadc_result_t res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  uadc_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_fire),
    .ua_byte (in_ua_byte),
    .is_last (in_is_last),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_is_last) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_os_kind     = res_r.os_kind;
  assign out_device_kind = res_r.device_kind;

`ifndef ASSERT_OFF
  // a final byte always yields a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_is_last) |=> out_valid)
    else $error("final byte did not produce a result");

  // ordinary bytes never create a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !(in_fire && in_is_last)) |=> !out_valid)
    else $error("result appeared without a final byte");

  // os and device are either both classified or both none
  a_kinds_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_os_kind == OS_NONE) == (out_device_kind == DEV_NONE)))
    else $error("os and device kinds disagree on no match");
`endif

endmodule

[sim/ua_kind_checker.sv]
`timescale 1ns / 100ps
// ua_kind_checker: watches the byte and result channels of the user-agent classifier,
// predicts the os/device kinds of every finished string and compares them in order
// depends on uadc_pkg for the kind enums and the result struct
module ua_kind_checker import uadc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ua_byte,
  input  logic       in_is_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_os_kind,
  input  logic [2:0] out_device_kind,
  output int         error_count,
  output int         outstanding,
  output int         result_count
);

  localparam int PLAT_N   = 19;
  localparam int MOZ_PLAT = 16;
  localparam int SAT_POS  = 63;

  string brand_text [2] = '{"Mozilla/", "Opera/"};

  // table order is priority order within each brand
  string plat_text [PLAT_N] = '{
    "(iPhone;", "(iPod;", "(iPad;", "(Linux; U; Android", "(Android", "(BlackBerry;",
    "(X11;", "(Macintosh;", "(Windows; U; MSIE", "(Windows NT",
    "(Windows; U; Windows NT", "(compatible; Windows; U;",
    "(compatible; MSIE 10.0; Macintosh;", "(compatible; MSIE 9.0; Windows Phone",
    "(compatible; MSIE 10.0; Windows NT 6.2; ARM;", "(compatible; MSIE",
    "(Windows", "(Macintosh;", "(X11;"
  };

  int plat_off [PLAT_N] = '{
    12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 11, 11, 11
  };

  os_kind_t plat_os [PLAT_N] = '{
    OS_IOS, OS_IOS, OS_IOS, OS_ANDROID, OS_ANDROID, OS_BLACKBERRY, OS_LINUX, OS_MAC,
    OS_WINDOWS, OS_WINDOWS, OS_WINDOWS, OS_WINDOWS, OS_MAC, OS_WINPHONE, OS_WINPHONE,
    OS_WINDOWS, OS_WINDOWS, OS_MAC, OS_LINUX
  };

  device_kind_t plat_dev [PLAT_N] = '{
    DEV_HANDSET, DEV_PLAYER, DEV_TABLET, DEV_MOBILE, DEV_MOBILE, DEV_BLACKBERRY, DEV_PC,
    DEV_MAC, DEV_PC, DEV_PC, DEV_PC, DEV_PC, DEV_MAC, DEV_MOBILE, DEV_MOBILE, DEV_PC,
    DEV_PC, DEV_MAC, DEV_PC
  };

  int                byte_pos;
  logic [1:0]        brand_live;
  logic [PLAT_N-1:0] plat_live;
  uadc_result_t      kind_q [$];

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
  endfunction

  // byte lands inside the text window and differs from it
  function automatic bit breaks_window(string txt, int off, int pos, logic [7:0] c);
    if (pos < off || pos >= off + txt.len()) return 1'b0;
    return lower_ascii(txt[pos - off]) != c;
  endfunction

  task automatic clear_string_state();
    byte_pos   = 0;
    brand_live = '1;
    plat_live  = '1;
  endtask

  task automatic predict_kind(input logic [7:0] b, input logic last,
                              output bit fires, output uadc_result_t res);
    int         len;
    int         lo;
    int         hi;
    logic [7:0] c;
    c = lower_ascii(b);
    for (int j = 0; j < 2; j++) begin
      if (breaks_window(brand_text[j], 0, byte_pos, c)) brand_live[j] = 1'b0;
    end
    for (int k = 0; k < PLAT_N; k++) begin
      if (breaks_window(plat_text[k], plat_off[k], byte_pos, c)) plat_live[k] = 1'b0;
    end
    if (byte_pos < SAT_POS) byte_pos++;
    fires = last;
    res.os_kind     = OS_NONE;
    res.device_kind = DEV_NONE;
    if (!last) return;
    len = byte_pos;
    lo  = 0;
    hi  = 0;
    if (brand_live[0] && len > brand_text[0].len()) begin
      hi = MOZ_PLAT;
    end else if (brand_live[1] && len > brand_text[1].len()) begin
      lo = MOZ_PLAT;
      hi = PLAT_N;
    end
    for (int k = lo; k < hi; k++) begin
      if (plat_live[k] && len > plat_off[k] + plat_text[k].len()) begin
        res.os_kind     = plat_os[k];
        res.device_kind = plat_dev[k];
        break;
      end
    end
    clear_string_state();
  endtask

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    bit           fires;
    uadc_result_t want;
    uadc_result_t got;
    if (!rst_n) begin
      clear_string_state();
      kind_q.delete();
    end else begin
      // result side first: a result can never belong to a byte taken at the same edge
      if (out_valid && out_ready) begin
        got.os_kind     = os_kind_t'(out_os_kind);
        got.device_kind = device_kind_t'(out_device_kind);
        if (kind_q.size() == 0) begin
          flag_error($sformatf("result with none expected (os %0d, device %0d)",
                               out_os_kind, out_device_kind));
        end else begin
          want = kind_q.pop_front();
          result_count++;
          if (want.os_kind != got.os_kind)
            flag_error($sformatf("os_kind expected %0d actual %0d",
                                 want.os_kind, got.os_kind));
          if (want.device_kind != got.device_kind)
            flag_error($sformatf("device_kind expected %0d actual %0d",
                                 want.device_kind, got.device_kind));
        end
      end
      if (in_valid && in_ready) begin
        predict_kind(in_ua_byte, in_is_last, fires, want);
        if (fires) kind_q.push_back(want);
      end
    end
    outstanding <= kind_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// testbench: streams directed and random user-agent strings into the classifier with
// random gaps and stalls; depends on user_agent_device_classifier_core and ua_kind_checker
module testbench;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_ua_byte = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_ready  = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [2:0] out_os_kind;
  wire  [2:0] out_device_kind;

  int error_count;
  int outstanding;
  int result_count;
  int strings_sent;
  int bytes_sent;
  bit calm;

  logic [7:0] ua_q [$];

  string plat_words [19] = '{
    "(iPhone;", "(iPod;", "(iPad;", "(Linux; U; Android", "(Android", "(BlackBerry;",
    "(X11;", "(Macintosh;", "(Windows; U; MSIE", "(Windows NT",
    "(Windows; U; Windows NT", "(compatible; Windows; U;",
    "(compatible; MSIE 10.0; Macintosh;", "(compatible; MSIE 9.0; Windows Phone",
    "(compatible; MSIE 10.0; Windows NT 6.2; ARM;", "(compatible; MSIE",
    "(Windows", "(Macintosh;", "(X11;"
  };

  user_agent_device_classifier_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ua_byte     (in_ua_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_os_kind    (out_os_kind),
    .out_device_kind(out_device_kind)
  );

  ua_kind_checker i_kind_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ua_byte     (in_ua_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_os_kind    (out_os_kind),
    .out_device_kind(out_device_kind),
    .error_count    (error_count),
    .outstanding    (outstanding),
    .result_count   (result_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic void load_text(string s);
    ua_q.delete();
    for (int i = 0; i < s.len(); i++) ua_q.push_back(s[i]);
  endfunction

  // random letter case, so matching has to ignore it
  function automatic void push_text(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1)) c ^= 8'h20;
      ua_q.push_back(c);
    end
  endfunction

  function automatic void push_fill(int n, bit printable);
    for (int i = 0; i < n; i++) begin
      if (printable) ua_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      else ua_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_ua(int plat);
    int pick;
    int base;
    int idx;
    int cut;
    ua_q.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      push_fill($urandom_range(1, 70), 1'b0);
      return;
    end
    // mostly the brand that owns the platform, now and then the other one
    if ((plat < 16) != (pick == 1)) begin
      push_text("Mozilla/");
      push_fill(4, 1'b1);
    end else begin
      push_text("Opera/");
      push_fill(5, 1'b1);
    end
    push_text(plat_words[plat]);
    if ($urandom_range(0, 4) == 0) begin
      idx = $urandom_range(0, ua_q.size() - 1);
      case ($urandom_range(0, 2))
        0:       ua_q[idx] ^= 8'h20;
        1:       ua_q[idx] ^= 8'($urandom_range(1, 255));
        default: ua_q[idx] = 8'h00;
      endcase
    end
    base = ua_q.size();
    case ($urandom_range(0, 5))
      0: begin
        // ends right at the pattern end, which is too short to count
      end
      1:       push_fill(1, 1'b1);
      2, 3:    push_fill($urandom_range(2, 12), 1'b1);
      4:       push_fill($urandom_range(58, 80) - base, 1'b0);
      default: begin
        cut = $urandom_range(1, base);
        while (ua_q.size() > cut) void'(ua_q.pop_back());
      end
    endcase
  endfunction

  task automatic send_ua();
    int gap;
    for (int i = 0; i < ua_q.size(); i++) begin
      gap = draw_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_ua_byte <= ua_q[i];
      in_is_last <= (i == ua_q.size() - 1);
      do @(posedge clk); while (!in_ready);
    end
    strings_sent++;
    bytes_sent += ua_q.size();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int plat;
    plat = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // single zero byte and single all-ones byte
    ua_q = '{8'h00};
    send_ua();
    ua_q = '{8'hFF};
    send_ua();
    // brand alone is not long enough to count
    load_text("Mozilla/");
    send_ua();
    // opera brand counts but no platform follows
    load_text("OPERA/x");
    send_ua();
    load_text("mOZILLA/5");
    send_ua();

    while (bytes_sent < 1976) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      build_ua(plat);
      plat = (plat + 1) % 19;
      send_ua();
      if (strings_sent == 30) drain();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("sent %0d user-agent strings (%0d bytes), checked %0d classifications",
             strings_sent, bytes_sent, result_count);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
rtl/uadc_pkg.sv
rtl/uadc_match.sv
rtl/user_agent_device_classifier_core.sv
sim/ua_kind_checker.sv
sim/testbench.sv
